// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the checker of the allocator.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PBA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PBA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/pba_pkg.sv =====
// Package of the paged bump allocator: beat types, codes, reset values
// and the controller/datapath command and status structs. No dependencies.
package pba_pkg;

  // Field widths of the beats and registers.
  localparam int unsigned SIZE_W   = 17;
  localparam int unsigned HDR_W    = 9;
  localparam int unsigned PAGE_W   = 4;
  localparam int unsigned COUNT_W  = 8;
  localparam int unsigned CFG_IDX_W = 2;

  // Alignment of every block, and the reciprocal used to round up to it.
  localparam int unsigned ALIGN_BYTES = 8;
  localparam int unsigned ALIGN_SHIFT = 24;
  localparam int unsigned RECIP_W     = 25;
  localparam int unsigned ALIGN_RECIP =
      ((1 << ALIGN_SHIFT) + ALIGN_BYTES - 1) / ALIGN_BYTES;
  // Widths inside the rounding unit.
  localparam int unsigned ALN_IN_W = SIZE_W + 1;
  localparam int unsigned PROD_W   = ALN_IN_W + RECIP_W;
  localparam int unsigned QUOT_W   = PROD_W - ALIGN_SHIFT;
  localparam int unsigned MULT_W   = QUOT_W + 7;

  // Register reset values.
  localparam logic [SIZE_W-1:0] PAGE_BYTES_RST  = 17'd4096;
  localparam logic [HDR_W-1:0]  FIRST_HDR_RST   = 9'd64;
  localparam logic [HDR_W-1:0]  LATER_HDR_RST   = 9'd32;
  localparam logic [SIZE_W-1:0] SMALL_LIMIT_RST = 17'd4032;

  // Fail counter limits.
  localparam logic [COUNT_W-1:0] FAIL_SKIP_LIMIT = 8'd4;
  localparam logic [COUNT_W-1:0] FAIL_MAX        = 8'd255;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PAGE_BYTES  = 2'd0,
    CFG_FIRST_HDR   = 2'd1,
    CFG_LATER_HDR   = 2'd2,
    CFG_SMALL_LIMIT = 2'd3
  } cfg_reg_e;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_RESET = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    STAT_OK         = 2'd0,
    STAT_TOO_LARGE  = 2'd1,
    STAT_FULL       = 2'd2,
    STAT_RESET_DONE = 2'd3
  } status_e;

  typedef struct packed {
    op_e               operation;
    logic [SIZE_W-1:0] size;
  } req_t;

  typedef struct packed {
    status_e           status;
    logic [PAGE_W-1:0] page;
    logic [SIZE_W-1:0] offset;
  } res_t;

  // One page record: fill offset and fail counter.
  typedef struct packed {
    logic [SIZE_W-1:0]  fill;
    logic [COUNT_W-1:0] fails;
  } page_entry_t;

  typedef enum logic [1:0] {
    IDX_HOLD,
    IDX_ZERO,
    IDX_CUR,
    IDX_INC
  } idx_op_e;

  typedef enum logic [2:0] {
    WR_NONE,
    WR_INIT,
    WR_CLEAR,
    WR_FILL,
    WR_BUMP,
    WR_OPEN
  } wr_op_e;

  typedef enum logic [1:0] {
    CUR_HOLD,
    CUR_ZERO,
    CUR_SKIP
  } cur_op_e;

  typedef enum logic [1:0] {
    RES_ZERO,
    RES_WALK,
    RES_OPEN
  } res_src_e;

  // Controller to datapath.
  typedef struct packed {
    logic     accept;
    idx_op_e  idx_op;
    logic     mem_rd;
    logic     aln_hdr;
    wr_op_e   wr_op;
    logic     hdr_save;
    cur_op_e  cur_op;
    logic     open_inc;
    logic     emit;
    status_e  status;
    res_src_e res_src;
  } pba_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic op_reset;
    logic too_large;
    logic fits;
    logic more_walk;
    logic more_p2;
    logic p2_any;
    logic pool_full;
  } pba_stat_t;

endpackage

// ===== hw/rtl/pba_ctrl.sv =====
// Controller state machine of the paged bump allocator.
// Depends on pba_pkg for the command and status structs.
module pba_ctrl
  import pba_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  output logic      busy,
  input  pba_stat_t stat_i,
  output pba_cmd_t  cmd_o
);

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_CLEAR,
    S_READ,
    S_ALIGN1,
    S_ALIGN2,
    S_CHECK,
    S_HDR1,
    S_HDR2,
    S_HDR_CHECK,
    S_P2_READ,
    S_P2_BUMP,
    S_OPEN
  } ctrl_state_e;

  ctrl_state_e state_q, state_d;
  logic        busy_q;

  // Next state and the commands issued in the current state.
  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    cmd_o.idx_op  = IDX_HOLD;
    cmd_o.wr_op   = WR_NONE;
    cmd_o.cur_op  = CUR_HOLD;
    cmd_o.status  = STAT_OK;
    cmd_o.res_src = RES_ZERO;
    case (state_q)
      S_INIT: begin
        cmd_o.wr_op = WR_INIT;
        state_d     = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd_o.accept = 1'b1;
          if (stat_i.op_reset) begin
            cmd_o.idx_op = IDX_ZERO;
            state_d      = S_CLEAR;
          end else if (stat_i.too_large) begin
            cmd_o.emit   = 1'b1;
            cmd_o.status = STAT_TOO_LARGE;
          end else begin
            cmd_o.idx_op = IDX_CUR;
            state_d      = S_READ;
          end
        end
      end
      S_CLEAR: begin
        cmd_o.wr_op = WR_CLEAR;
        if (stat_i.more_walk) begin
          cmd_o.idx_op = IDX_INC;
        end else begin
          cmd_o.cur_op = CUR_ZERO;
          cmd_o.emit   = 1'b1;
          cmd_o.status = STAT_RESET_DONE;
          state_d      = S_IDLE;
        end
      end
      S_READ: begin
        cmd_o.mem_rd = 1'b1;
        state_d      = S_ALIGN1;
      end
      S_ALIGN1: begin
        state_d = S_ALIGN2;
      end
      S_ALIGN2: begin
        state_d = S_CHECK;
      end
      S_CHECK: begin
        if (stat_i.fits) begin
          cmd_o.wr_op   = WR_FILL;
          cmd_o.emit    = 1'b1;
          cmd_o.res_src = RES_WALK;
          state_d       = S_IDLE;
        end else begin
          cmd_o.wr_op = WR_BUMP;
          if (stat_i.more_walk) begin
            cmd_o.idx_op = IDX_INC;
            state_d      = S_READ;
          end else if (stat_i.pool_full) begin
            cmd_o.emit   = 1'b1;
            cmd_o.status = STAT_FULL;
            state_d      = S_IDLE;
          end else begin
            state_d = S_HDR1;
          end
        end
      end
      S_HDR1: begin
        cmd_o.aln_hdr = 1'b1;
        state_d       = S_HDR2;
      end
      S_HDR2: begin
        state_d = S_HDR_CHECK;
      end
      S_HDR_CHECK: begin
        if (stat_i.fits) begin
          cmd_o.hdr_save = 1'b1;
          cmd_o.idx_op   = IDX_CUR;
          state_d        = stat_i.p2_any ? S_P2_READ : S_OPEN;
        end else begin
          cmd_o.emit   = 1'b1;
          cmd_o.status = STAT_TOO_LARGE;
          state_d      = S_IDLE;
        end
      end
      S_P2_READ: begin
        cmd_o.mem_rd = 1'b1;
        state_d      = S_P2_BUMP;
      end
      S_P2_BUMP: begin
        cmd_o.wr_op  = WR_BUMP;
        cmd_o.cur_op = CUR_SKIP;
        cmd_o.idx_op = IDX_INC;
        state_d      = stat_i.more_p2 ? S_P2_READ : S_OPEN;
      end
      S_OPEN: begin
        cmd_o.wr_op    = WR_OPEN;
        cmd_o.open_inc = 1'b1;
        cmd_o.emit     = 1'b1;
        cmd_o.res_src  = RES_OPEN;
        state_d        = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State register and the registered busy flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
      busy_q  <= 1'b1;
    end else begin
      state_q <= state_d;
      busy_q  <= (state_d != S_IDLE);
    end
  end

  assign busy = busy_q;

endmodule

// ===== hw/rtl/pba_datapath.sv =====
// Datapath of the paged bump allocator: configuration registers, page
// memory, shared rounding unit, walk index and result register. Uses pba_pkg.
module pba_datapath
  import pba_pkg::*;
#(
  parameter int unsigned MAX_PAGES = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [SIZE_W-1:0]    cfg_data_i,
  input  req_t                 req_i,
  input  pba_cmd_t             cmd_i,
  output pba_stat_t            stat_o,
  output logic                 done_o,
  output res_t                 res_o
);

  localparam int unsigned IW   = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
  localparam int unsigned CW   = $clog2(MAX_PAGES + 1);
  localparam int unsigned CMPW = CW + 1;
  localparam int unsigned EXTW = 9;

  // Configuration registers.
  logic [SIZE_W-1:0] page_bytes_q, small_limit_q;
  logic [HDR_W-1:0]  first_hdr_q, later_hdr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      page_bytes_q  <= PAGE_BYTES_RST;
      first_hdr_q   <= FIRST_HDR_RST;
      later_hdr_q   <= LATER_HDR_RST;
      small_limit_q <= SMALL_LIMIT_RST;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        CFG_PAGE_BYTES:  page_bytes_q  <= cfg_data_i;
        CFG_FIRST_HDR:   first_hdr_q   <= cfg_data_i[HDR_W-1:0];
        CFG_LATER_HDR:   later_hdr_q   <= cfg_data_i[HDR_W-1:0];
        CFG_SMALL_LIMIT: small_limit_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Request size, captured on the accepted beat.
  logic [SIZE_W-1:0] size_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      size_q <= req_i.size;
    end
  end

  // Walk index, current page and the count of opened pages.
  logic [IW-1:0] idx_q, cur_q;
  logic [CW-1:0] pages_open_q;
  logic [IW-1:0] idx_inc;
  page_entry_t   rd_q;
  logic          skip;

  assign idx_inc = IW'(idx_q + 1'b1);
  assign skip    = (rd_q.fails > FAIL_SKIP_LIMIT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q        <= '0;
      cur_q        <= '0;
      pages_open_q <= CW'(1);
    end else begin
      case (cmd_i.idx_op)
        IDX_ZERO: idx_q <= '0;
        IDX_CUR:  idx_q <= cur_q;
        IDX_INC:  idx_q <= idx_inc;
        default:  idx_q <= idx_q;
      endcase
      case (cmd_i.cur_op)
        CUR_ZERO: cur_q <= '0;
        CUR_SKIP: cur_q <= skip ? idx_inc : cur_q;
        default:  cur_q <= cur_q;
      endcase
      if (cmd_i.open_inc) begin
        pages_open_q <= pages_open_q + 1'b1;
      end
    end
  end

  // Shared rounding unit: reciprocal multiply, then multiply back.
  logic [ALN_IN_W-1:0] aln_y;
  logic [PROD_W-1:0]   prod_q;
  logic [QUOT_W-1:0]   quot;
  logic [MULT_W-1:0]   m_full;
  logic [ALN_IN_W-1:0] m_q, hdr_m_q;

  assign aln_y  = cmd_i.aln_hdr ? ALN_IN_W'(later_hdr_q) + ALN_IN_W'(ALIGN_BYTES - 1)
                                : ALN_IN_W'(rd_q.fill) + ALN_IN_W'(ALIGN_BYTES - 1);
  assign quot   = prod_q[PROD_W-1:ALIGN_SHIFT];
  assign m_full = MULT_W'(quot) * MULT_W'(ALIGN_BYTES);

  always_ff @(posedge clk_i) begin
    prod_q <= PROD_W'(aln_y) * PROD_W'(ALIGN_RECIP);
    m_q    <= m_full[ALN_IN_W-1:0];
    if (cmd_i.hdr_save) begin
      hdr_m_q <= m_q;
    end
  end

  // Fit test of the rounded offset against the page end.
  logic [ALN_IN_W-1:0] pb_ext, room;
  logic                fits;

  assign pb_ext = ALN_IN_W'(page_bytes_q);
  assign room   = pb_ext - m_q;
  assign fits   = (m_q <= pb_ext) && (room >= ALN_IN_W'(size_q));

  // Page memory: one write and one registered read a cycle.
  page_entry_t       mem_q [MAX_PAGES];
  page_entry_t       wr_data;
  logic [IW-1:0]     wr_addr;
  logic              wr_en;
  logic [COUNT_W-1:0] fails_bumped;
  logic [SIZE_W-1:0] walk_fill, open_fill;

  assign fails_bumped = (rd_q.fails < FAIL_MAX) ? rd_q.fails + 1'b1 : rd_q.fails;
  assign walk_fill    = SIZE_W'(m_q + ALN_IN_W'(size_q));
  assign open_fill    = SIZE_W'(hdr_m_q + ALN_IN_W'(size_q));

  always_comb begin
    wr_en   = 1'b1;
    wr_addr = idx_q;
    wr_data = rd_q;
    case (cmd_i.wr_op)
      WR_INIT: begin
        wr_addr = '0;
        wr_data = '{fill: SIZE_W'(FIRST_HDR_RST), fails: '0};
      end
      WR_CLEAR: wr_data = '{fill: SIZE_W'(first_hdr_q), fails: '0};
      WR_FILL:  wr_data = '{fill: walk_fill, fails: rd_q.fails};
      WR_BUMP:  wr_data = '{fill: rd_q.fill, fails: fails_bumped};
      WR_OPEN: begin
        wr_addr = pages_open_q[IW-1:0];
        wr_data = '{fill: open_fill, fails: '0};
      end
      default: wr_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (cmd_i.mem_rd) begin
      rd_q <= mem_q[idx_q];
    end
  end

  // Status towards the controller.
  logic [CMPW-1:0] idx_ext, cur_ext, open_ext;

  assign idx_ext  = CMPW'(idx_q);
  assign cur_ext  = CMPW'(cur_q);
  assign open_ext = CMPW'(pages_open_q);

  assign stat_o.op_reset  = (req_i.operation == OP_RESET);
  assign stat_o.too_large = (req_i.size > small_limit_q);
  assign stat_o.fits      = fits;
  assign stat_o.more_walk = (idx_ext + CMPW'(1)) < open_ext;
  assign stat_o.more_p2   = (idx_ext + CMPW'(2)) < open_ext;
  assign stat_o.p2_any    = (cur_ext + CMPW'(1)) < open_ext;
  assign stat_o.pool_full = (pages_open_q >= CW'(MAX_PAGES));

  // Result beat, shown for one cycle.
  logic [EXTW-1:0] idx_pg, open_pg;
  logic            done_q;
  res_t            res_q;

  assign idx_pg  = EXTW'(idx_q);
  assign open_pg = EXTW'(pages_open_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= cmd_i.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      res_q.status <= cmd_i.status;
      case (cmd_i.res_src)
        RES_WALK: begin
          res_q.page   <= idx_pg[PAGE_W-1:0];
          res_q.offset <= SIZE_W'(m_q);
        end
        RES_OPEN: begin
          res_q.page   <= open_pg[PAGE_W-1:0];
          res_q.offset <= SIZE_W'(hdr_m_q);
        end
        default: begin
          res_q.page   <= '0;
          res_q.offset <= '0;
        end
      endcase
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

// ===== hw/rtl/paged_bump_allocator_unit.sv =====
// Top level of the paged bump allocator: controller plus datapath.
// Depends on pba_pkg, pba_ctrl and pba_datapath.
//
// Usage: a request beat (allocate with a size, or reset the pool) is taken
// at a rising edge where start is high and busy is low. Exactly one result
// beat follows, shown on res_o for one cycle while done_o is high; the
// receiver cannot hold it off. The user writes configuration through cfg_we_i,
// cfg_idx_i and cfg_data_i only while the block is idle; the block itself
// does not enforce this. Work from the accepted beat to the result beat:
//   too large on entry: the result beat is issued straight from idle;
//   allocation from an open page: a walk from the current page, each page
//   tried taking a page memory read, two rounding multiplies and a check;
//   new page opened: the walk, then the header rounding, the fail count
//   pass and the open step;
//   pool full: the walk only; pool reset: a sweep over the opened pages.
// The page memory has a single read port and the rounding unit is shared;
// one request is worked on at a time.
// After reset the block initialises page 0 with busy high, then sits idle
// with one page open.
module paged_bump_allocator_unit
  import pba_pkg::*;
#(
  parameter int unsigned MAX_PAGES = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  req_t                 req_i,
  output logic                 done_o,
  output res_t                 res_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [SIZE_W-1:0]    cfg_data_i
);

  pba_cmd_t  cmd;
  pba_stat_t stat;

  // Sequencer of the walk, the second pass and the pool reset sweep.
  pba_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  // Page store, rounding unit and result register.
  pba_datapath #(
    .MAX_PAGES (MAX_PAGES)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .req_i      (req_i),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .done_o     (done_o),
    .res_o      (res_o)
  );

endmodule

// ===== hw/rtl/pba_checker.sv =====
// Port-level checker of the paged bump allocator, bound to the top level.
// Depends on pba_pkg and assert_macros.svh.
`include "assert_macros.svh"

module pba_checker
  import pba_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic done_o,
  input res_t res_o
);

  // An accepted beat either keeps the block busy or is answered at once.
  `PBA_ASSERT_NXT(a_accept_acts, start && !busy, busy || done_o, "accepted beat ignored")

  // A result beat is only shown once the block is back to idle.
  `PBA_ASSERT_IMP(a_done_idle, done_o, !busy, "result beat while busy")

  // Every result beat traces back to an accepted beat or ongoing work.
  `PBA_ASSERT_IMP(a_done_cause, done_o, $past(busy) || $past(start), "result without request")

  // Results other than an allocation carry page and offset zero.
  `PBA_ASSERT_IMP(a_zero_fields, done_o && (res_o.status != STAT_OK),
                  (res_o.page == '0) && (res_o.offset == '0), "non-zero fields on refusal")

endmodule

bind paged_bump_allocator_unit pba_checker u_pba_checker (.*);
